### rtl/next_hop_rtt_cost_selector_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the next-hop RTT cost selector
// Clocked on clk, disabled while rst_n is low; both names must be in scope.
// ---------------------------------------------------------------------------
`ifndef NEXT_HOP_RTT_COST_SELECTOR_ASSERT_SVH
`define NEXT_HOP_RTT_COST_SELECTOR_ASSERT_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define NHRCS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nhrcs assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define NHRCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nhrcs assertion failed");
`else
`define NHRCS_ASSERT_SAME(label, ante, cons)
`define NHRCS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/nhrcs_pkg.sv
// ---------------------------------------------------------------------------
// nhrcs_pkg
// Shared widths, RTT status codes and choice kinds of the next-hop selector.
// ---------------------------------------------------------------------------
package nhrcs_pkg;

  localparam int DEF_FACE_BITS = 16;
  localparam int DEF_RTT_BITS  = 32;
  localparam int COST_BITS     = 16;
  localparam int CLASS_BITS    = 2;
  localparam int KIND_BITS     = 3;

  // RTT status of a hop; any code at or above timed-out counts as timed out
  localparam logic [CLASS_BITS-1:0] CLASS_MEASURED   = 2'd0;
  localparam logic [CLASS_BITS-1:0] CLASS_UNMEASURED = 2'd1;
  localparam logic [CLASS_BITS-1:0] CLASS_TIMEOUT    = 2'd2;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_RANKED           = 3'd0,
    KIND_PREVIOUS         = 3'd1,
    KIND_LOWEST_RTT       = 3'd2,
    KIND_FIRST_UNMEASURED = 3'd3,
    KIND_BACKUP           = 3'd4
  } choice_kind_t;

endpackage

### rtl/nhrcs_accum.sv
// ---------------------------------------------------------------------------
// nhrcs_accum
// Running per-decision minima, sticky face and the final choice logic.
// ---------------------------------------------------------------------------
`include "next_hop_rtt_cost_selector_assert.svh"

module nhrcs_accum
  import nhrcs_pkg::*;
#(
  parameter int FACE_BITS = DEF_FACE_BITS,
  parameter int RTT_BITS  = DEF_RTT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic                  hop_valid,
  input  logic [FACE_BITS-1:0]  hop_face,
  input  logic [CLASS_BITS-1:0] hop_class,
  input  logic [RTT_BITS-1:0]   hop_rtt,
  input  logic [RTT_BITS-1:0]   hop_srtt,
  input  logic [COST_BITS-1:0]  hop_cost,
  input  logic [FACE_BITS-1:0]  arrival_face,
  input  logic                  learning_mode,
  input  logic                  list_end,
  output logic [FACE_BITS-1:0]  res_face,
  output logic                  res_found,
  output choice_kind_t          res_kind
);

  localparam int KEY_BITS = RTT_BITS + 2;

  logic [FACE_BITS-1:0] sticky_face_r, sticky_face_nxt;
  logic                 sticky_valid_r, sticky_valid_nxt;
  logic                 seen_to_r, seen_to_nxt;
  logic [FACE_BITS-1:0] rank_face_r, rank_face_nxt;
  logic [KEY_BITS-1:0]  rank_key_r, rank_key_nxt;
  logic [COST_BITS-1:0] rank_cost_r, rank_cost_nxt;
  logic                 rank_valid_r, rank_valid_nxt;
  logic [FACE_BITS-1:0] mr_face_r, mr_face_nxt;
  logic [RTT_BITS-1:0]  mr_value_r, mr_value_nxt;
  logic                 mr_valid_r, mr_valid_nxt;
  logic [FACE_BITS-1:0] um_face_r, um_face_nxt;
  logic                 um_valid_r, um_valid_nxt;
  logic [FACE_BITS-1:0] fb_face_r, fb_face_nxt;
  logic                 fb_valid_r, fb_valid_nxt;

  logic                 timed_out;
  logic                 unmeasured;
  logic                 eligible;
  logic [KEY_BITS-1:0]  key;
  logic                 rank_upd;
  logic                 mr_upd;
  logic                 um_upd;
  logic                 fb_upd;
  logic                 seen_a;
  logic                 keep_sticky;

  // Classify the hop and build its ranking key
  assign timed_out  = (hop_class >= CLASS_TIMEOUT);
  assign unmeasured = (hop_class == CLASS_UNMEASURED);
  assign eligible   = hop_valid && (hop_face != arrival_face);

  always_comb begin
    if (timed_out) begin
      key = {KEY_BITS{1'b1}};
    end else if (unmeasured) begin
      key = {1'b0, {(KEY_BITS-1){1'b1}}};
    end else begin
      key = {2'b00, hop_srtt};
    end
  end

  // Decide which running records this hop replaces
  assign rank_upd = eligible && (!rank_valid_r || (key < rank_key_r) ||
                    ((key == rank_key_r) && (hop_cost < rank_cost_r)));
  assign mr_upd   = eligible && !timed_out && !unmeasured &&
                    (!mr_valid_r || (hop_rtt < mr_value_r));
  assign um_upd   = eligible && unmeasured && !um_valid_r;
  assign fb_upd   = eligible && !fb_valid_r;

  // Sticky face status counts every hop, arrival face included
  assign seen_a = seen_to_r || (hop_valid && sticky_valid_r &&
                  (hop_face == sticky_face_r) && timed_out);
  assign keep_sticky = sticky_valid_r && !seen_a;

  // Pick the result from the records as updated by this hop
  always_comb begin
    res_face  = '0;
    res_found = 1'b0;
    res_kind  = KIND_RANKED;
    if (learning_mode) begin
      if (keep_sticky) begin
        res_face  = sticky_face_r;
        res_found = 1'b1;
        res_kind  = KIND_PREVIOUS;
      end else if (mr_upd || mr_valid_r) begin
        res_face  = mr_upd ? hop_face : mr_face_r;
        res_found = 1'b1;
        res_kind  = KIND_LOWEST_RTT;
      end else if (um_upd || um_valid_r) begin
        res_face  = um_upd ? hop_face : um_face_r;
        res_found = 1'b1;
        res_kind  = KIND_FIRST_UNMEASURED;
      end else if (fb_upd || fb_valid_r) begin
        res_face  = fb_upd ? hop_face : fb_face_r;
        res_found = 1'b1;
        res_kind  = KIND_BACKUP;
      end
    end else if (rank_upd || rank_valid_r) begin
      res_face  = rank_upd ? hop_face : rank_face_r;
      res_found = 1'b1;
    end
  end

  // Advance the records; close the decision on the last hop
  always_comb begin
    sticky_face_nxt  = sticky_face_r;
    sticky_valid_nxt = sticky_valid_r;
    seen_to_nxt      = seen_a;
    rank_face_nxt    = rank_upd ? hop_face : rank_face_r;
    rank_key_nxt     = rank_upd ? key : rank_key_r;
    rank_cost_nxt    = rank_upd ? hop_cost : rank_cost_r;
    rank_valid_nxt   = rank_valid_r || eligible;
    mr_face_nxt      = mr_upd ? hop_face : mr_face_r;
    mr_value_nxt     = mr_upd ? hop_rtt : mr_value_r;
    mr_valid_nxt     = mr_valid_r || mr_upd;
    um_face_nxt      = um_upd ? hop_face : um_face_r;
    um_valid_nxt     = um_valid_r || um_upd;
    fb_face_nxt      = fb_upd ? hop_face : fb_face_r;
    fb_valid_nxt     = fb_valid_r || fb_upd;
    if (list_end) begin
      seen_to_nxt    = 1'b0;
      rank_valid_nxt = 1'b0;
      mr_valid_nxt   = 1'b0;
      um_valid_nxt   = 1'b0;
      fb_valid_nxt   = 1'b0;
      if (learning_mode && !keep_sticky) begin
        sticky_face_nxt  = res_face;
        sticky_valid_nxt = res_found;
      end
    end
  end

  // Hold control bits under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sticky_valid_r <= 1'b0;
      seen_to_r      <= 1'b0;
      rank_valid_r   <= 1'b0;
      mr_valid_r     <= 1'b0;
      um_valid_r     <= 1'b0;
      fb_valid_r     <= 1'b0;
    end else if (fire) begin
      sticky_valid_r <= sticky_valid_nxt;
      seen_to_r      <= seen_to_nxt;
      rank_valid_r   <= rank_valid_nxt;
      mr_valid_r     <= mr_valid_nxt;
      um_valid_r     <= um_valid_nxt;
      fb_valid_r     <= fb_valid_nxt;
    end
  end

  // Record payloads, only read while their valid bit is set
  always_ff @(posedge clk) begin
    if (fire) begin
      sticky_face_r <= sticky_face_nxt;
      rank_face_r   <= rank_face_nxt;
      rank_key_r    <= rank_key_nxt;
      rank_cost_r   <= rank_cost_nxt;
      mr_face_r     <= mr_face_nxt;
      mr_value_r    <= mr_value_nxt;
      um_face_r     <= um_face_nxt;
      fb_face_r     <= fb_face_nxt;
    end
  end

  `NHRCS_ASSERT_NEXT(a_clear_on_end, fire && list_end, !rank_valid_r && !mr_valid_r && !um_valid_r && !fb_valid_r && !seen_to_r)
  `NHRCS_ASSERT_SAME(a_fallback_covers, rank_valid_r || mr_valid_r || um_valid_r, fb_valid_r)
  `NHRCS_ASSERT_NEXT(a_sticky_learn, fire && list_end && learning_mode && !keep_sticky, sticky_valid_r == $past(res_found))

endmodule

### rtl/next_hop_rtt_cost_selector.sv
// ---------------------------------------------------------------------------
// next_hop_rtt_cost_selector
// Chooses the outgoing face of one forwarding decision from its next hops.
// ---------------------------------------------------------------------------
// Usage: present the next hops of one decision on the in_ channel, one hop
// per request, in cost order; mark the final one with in_list_end. An item
// with in_hop_valid low carries no hop (use it with in_list_end to close an
// empty list). in_learning_mode is sampled on the final item only.
// Each decision yields exactly one out_ request: the chosen face, a found
// flag and the kind of choice. Other items yield nothing.
// The final item passes from the input register through the running minima
// into the result register, which raises out_valid.
// Throughput: one hop per cycle while no final hop waits; the single
// compare-and-update pass over the running minima between the input and
// result registers sets it. Stall: while the result register is full and
// out_ready is low, hops that do not end a decision still advance; a final hop
// waits in the input register and in_ready drops until the result is taken.
// Reset: synchronous; clears the sticky face and all per-decision records.
// ---------------------------------------------------------------------------
`include "next_hop_rtt_cost_selector_assert.svh"

module next_hop_rtt_cost_selector
  import nhrcs_pkg::*;
#(
  parameter int FACE_BITS = DEF_FACE_BITS,
  parameter int RTT_BITS  = DEF_RTT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_hop_valid,
  input  logic [FACE_BITS-1:0]  in_hop_face,
  input  logic [CLASS_BITS-1:0] in_hop_class,
  input  logic [RTT_BITS-1:0]   in_hop_rtt,
  input  logic [RTT_BITS-1:0]   in_hop_srtt,
  input  logic [COST_BITS-1:0]  in_hop_cost,
  input  logic [FACE_BITS-1:0]  in_arrival_face,
  input  logic                  in_learning_mode,
  input  logic                  in_list_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FACE_BITS-1:0]  out_chosen_face,
  output logic                  out_found,
  output logic [KIND_BITS-1:0]  out_choice_kind
);

  logic                  in_valid_r;
  logic                  hop_valid_r;
  logic [FACE_BITS-1:0]  hop_face_r;
  logic [CLASS_BITS-1:0] hop_class_r;
  logic [RTT_BITS-1:0]   hop_rtt_r;
  logic [RTT_BITS-1:0]   hop_srtt_r;
  logic [COST_BITS-1:0]  hop_cost_r;
  logic [FACE_BITS-1:0]  arrival_face_r;
  logic                  learning_mode_r;
  logic                  list_end_r;

  logic                  out_valid_r;
  logic [FACE_BITS-1:0]  out_face_r;
  logic                  out_found_r;
  choice_kind_t          out_kind_r;

  logic                  fire;
  logic                  res_load;
  logic [FACE_BITS-1:0]  res_face;
  logic                  res_found;
  choice_kind_t          res_kind;

  // Advance the held hop unless it ends a decision and the result slot is busy
  assign fire     = in_valid_r && (!list_end_r || !out_valid_r || out_ready);
  assign res_load = fire && list_end_r;
  assign in_ready = !in_valid_r || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hop_valid_r     <= in_hop_valid;
      hop_face_r      <= in_hop_face;
      hop_class_r     <= in_hop_class;
      hop_rtt_r       <= in_hop_rtt;
      hop_srtt_r      <= in_hop_srtt;
      hop_cost_r      <= in_hop_cost;
      arrival_face_r  <= in_arrival_face;
      learning_mode_r <= in_learning_mode;
      list_end_r      <= in_list_end;
    end
  end

  nhrcs_accum #(
    .FACE_BITS (FACE_BITS),
    .RTT_BITS  (RTT_BITS)
  ) u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .hop_valid     (hop_valid_r),
    .hop_face      (hop_face_r),
    .hop_class     (hop_class_r),
    .hop_rtt       (hop_rtt_r),
    .hop_srtt      (hop_srtt_r),
    .hop_cost      (hop_cost_r),
    .arrival_face  (arrival_face_r),
    .learning_mode (learning_mode_r),
    .list_end      (list_end_r),
    .res_face      (res_face),
    .res_found     (res_found),
    .res_kind      (res_kind)
  );

  // Result register: load on a closing hop, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_face_r  <= res_face;
      out_found_r <= res_found;
      out_kind_r  <= res_kind;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_chosen_face = out_face_r;
  assign out_found       = out_found_r;
  assign out_choice_kind = out_kind_r;

  `NHRCS_ASSERT_SAME(a_hold_final, in_valid_r && list_end_r && out_valid_r && !out_ready, !in_ready && !fire)
  `NHRCS_ASSERT_NEXT(a_load_result, res_load, out_valid_r)
  `NHRCS_ASSERT_NEXT(a_no_phantom, !res_load && (!out_valid_r || out_ready), !out_valid_r)

endmodule
